// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
package spq_pkg;

   localparam int VALUE_W = 32;
   localparam int PRIO_W  = 8;
   localparam int OCC_W   = 5;
   localparam logic [PRIO_W-1:0] PRIO_CAP_RESET = 8'd100;

   // transaction op codes; code 3 is a no-op
   typedef enum logic [1:0] {
      MODE_PLAIN   = 2'd0,
      MODE_PRIO    = 2'd1,
      MODE_DEQUEUE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]         pri;
   } entry_type;

   // broadcast from the queue control to every cell
   typedef struct packed {
      logic      insert;      // enqueue that will be stored
      logic      prio_insert; // enqueue that searches by priority
      logic      dequeue;     // pop of a non-empty queue
      entry_type new_entry;
   } cell_ctl_type;

endpackage

// ----- rtl/spq_req_if.sv -----
`timescale 1ns / 1ps
interface spq_req_if
   import spq_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                mode;
   logic signed [VALUE_W-1:0] item_value;
   logic [PRIO_W-1:0]         item_priority;

   modport source (output valid, output mode, output item_value, output item_priority,
                   input ready);
   modport sink   (input valid, input mode, input item_value, input item_priority,
                   output ready);
endinterface

// ----- rtl/spq_rsp_if.sv -----
`timescale 1ns / 1ps
interface spq_rsp_if
   import spq_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] head_value;
   logic [1:0]                status;
   logic [OCC_W-1:0]          occupancy;

   modport source (output valid, output head_value, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input head_value, input status, input occupancy,
                   output ready);
endinterface

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps
module spq_cell
   import spq_pkg::*;
#(
   parameter bit HEAD_CELL = 1'b0
) (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  entry_type    left_entry,
   input  logic         left_valid,
   input  logic         moved_in,
   input  entry_type    right_entry,
   input  logic         right_valid,
   output entry_type    entry,
   output logic         valid,
   output logic         moved_out
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;
   logic      hit, take_new;

   // head is displaced only by a strictly more urgent entry
   always_comb begin
      if (HEAD_CELL) begin
         hit = valid_ff && ctl.prio_insert && (ctl.new_entry.pri < entry_ff.pri);
      end else begin
         hit = valid_ff && ctl.prio_insert && (entry_ff.pri >= ctl.new_entry.pri);
      end
   end

   assign moved_out = moved_in || hit;
   assign take_new  = ctl.insert && !moved_in && (hit || (!valid_ff && left_valid));

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctl.dequeue) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end else if (ctl.insert && moved_in) begin
         // shift right: an empty neighbor stays empty past the tail
         entry_in = left_entry;
         valid_in = left_valid;
      end else if (take_new) begin
         entry_in = ctl.new_entry;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

// ----- rtl/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// Sorted priority queue of up to QUEUE_DEPTH (value, priority) entries, lower
// priority number = more urgent. Each req transaction is one op: mode 0 appends
// at the tail with priority = cap, mode 1 clamps the priority to the cap and
// inserts it (to the front only if strictly more urgent than the head, else
// ahead of the first later entry of equal or larger number), mode 2 pops the
// head, mode 3 does nothing. Every req transaction yields exactly one rsp
// transaction with the popped value (else zero), a status (done / empty / full)
// and the occupancy after the op. Entries live in a row of cells that all shift
// in the same cycle, so a new req transaction is taken every cycle while
// the rsp register is free or being drained. The
// insertion point ripples as a "moved" flag from the head cell to the tail
// cell; that chain sets the critical path and grows with QUEUE_DEPTH.
// csr_wr_en writes the 8-bit priority cap (reset 100); write it only while idle.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [PRIO_W-1:0] csr_wr_data,
   spq_req_if.sink           req,
   spq_rsp_if.source         rsp
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // ---------------- configuration ----------------
   logic [PRIO_W-1:0] cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= PRIO_CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // ---------------- handshake ----------------
   logic rsp_valid_ff, rsp_valid_in;
   logic req_fire;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;

   // ---------------- op decode ----------------
   logic [CNT_W-1:0] count_ff, count_in;
   logic             full, empty, is_enq, is_prio, is_deq;
   logic [PRIO_W-1:0] clamp_pri;
   cell_ctl_type     ctl;
   status_type       status_in;

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      is_enq  = 1'b0;
      is_prio = 1'b0;
      is_deq  = 1'b0;
      case (req.mode)
         MODE_PLAIN:   is_enq = 1'b1;
         MODE_PRIO: begin
            is_enq  = 1'b1;
            is_prio = 1'b1;
         end
         MODE_DEQUEUE: is_deq = 1'b1;
         default: ;
      endcase
   end

   assign clamp_pri = (req.item_priority > cap_ff) ? cap_ff : req.item_priority;

   always_comb begin
      ctl.insert          = req_fire && is_enq && !full;
      ctl.prio_insert     = req_fire && is_prio && !full;
      ctl.dequeue         = req_fire && is_deq && !empty;
      ctl.new_entry.value = req.item_value;
      ctl.new_entry.pri   = is_prio ? clamp_pri : cap_ff;
   end

   always_comb begin
      count_in  = count_ff;
      status_in = STAT_DONE;
      if (ctl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.dequeue) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (is_enq && full) begin
         status_in = STAT_FULL;
      end else if (is_deq && empty) begin
         status_in = STAT_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // ---------------- cell row ----------------
   entry_type                cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   cell_valid;
   logic [QUEUE_DEPTH:0]     moved;     // moved[i]: insertion point lies left of cell i

   assign moved[0] = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      left_v, right_v;

      if (i == 0) begin : g_head
         assign left_e = '0;
         assign left_v = 1'b1;      // empty queue: head cell takes the new entry
      end else begin : g_mid
         assign left_e = cell_entry[i-1];
         assign left_v = cell_valid[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_e = '0;
         assign right_v = 1'b0;
      end else begin : g_body
         assign right_e = cell_entry[i+1];
         assign right_v = cell_valid[i+1];
      end

      spq_cell #(
         .HEAD_CELL (i == 0)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_entry  (left_e),
         .left_valid  (left_v),
         .moved_in    (moved[i]),
         .right_entry (right_e),
         .right_valid (right_v),
         .entry       (cell_entry[i]),
         .valid       (cell_valid[i]),
         .moved_out   (moved[i+1])
      );
   end

   // ---------------- response register ----------------
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic [1:0]                rsp_status_ff;
   logic [OCC_W-1:0]          rsp_occ_ff;

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_value_ff  <= ctl.dequeue ? cell_entry[0].value : '0;
         rsp_status_ff <= status_in;
         rsp_occ_ff    <= OCC_W'(count_in);
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.head_value = rsp_value_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.occupancy  = rsp_occ_ff;

   // ---------------- assertions ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count above depth");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      cell_valid[0] == !empty)
      else $error("head cell valid disagrees with count");

   a_tail_valid: assert property (@(posedge clock) disable iff (reset)
      cell_valid[QUEUE_DEPTH-1] == full)
      else $error("tail cell valid disagrees with count");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      ctl.insert |-> !(moved[QUEUE_DEPTH] && cell_valid[QUEUE_DEPTH-1]))
      else $error("insert shifted an entry off the tail");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_enq && full) |=> (rsp_status_ff == STAT_FULL) && $stable(count_ff))
      else $error("enqueue into full queue not rejected");

endmodule

// ----- tb/sorted_priority_queue_tb.sv -----
`timescale 1ns / 1ps
module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   // mode code 3 has no name in the package; the block treats it as a no-op
   localparam logic [1:0] MODE_NOP = 2'd3;

   // one response transaction as the queue should report it
   typedef struct packed {
      logic signed [VALUE_W-1:0] head_value;
      status_type                status;
      logic [OCC_W-1:0]          occupancy;
   } outcome_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [PRIO_W-1:0] csr_wr_data;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   sorted_priority_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req        (req_bus),
      .rsp        (rsp_bus)
   );

   // shadow copy of the queue: front of the SV queue is the head entry
   entry_type         shadow_entries[$];
   logic [PRIO_W-1:0] shadow_cap;
   // responses still owed by the block, oldest first
   outcome_type       outcome_fifo[$];
   int                mismatch_count = 0;

   // idle odds in percent per cycle for each side
   int                req_gap_pct = 24;
   int                rsp_gap_pct = 24;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // response side: drop ready at random, new decision every cycle
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_gap_pct);
   end

   // Applies one operation to the shadow queue and returns what the block must answer.
   function automatic outcome_type apply_queue_op(input logic [1:0] op,
                                                  input logic signed [VALUE_W-1:0] value,
                                                  input logic [PRIO_W-1:0] pri);
      outcome_type res;
      entry_type   ent;
      int          pos;
      res = '0;
      case (op)
         MODE_PLAIN, MODE_PRIO: begin
            if (shadow_entries.size() >= QUEUE_DEPTH) begin
               // full: transaction dropped, queue untouched
               res.status = STAT_FULL;
            end else if (op == MODE_PLAIN) begin
               ent.value = value;
               ent.pri   = shadow_cap;
               shadow_entries.push_back(ent);
            end else begin
               ent.value = value;
               ent.pri   = (pri > shadow_cap) ? shadow_cap : pri;
               // front only when strictly more urgent than the head; otherwise
               // ahead of the first later entry with an equal or larger number
               if (shadow_entries.size() == 0 || ent.pri < shadow_entries[0].pri) begin
                  pos = 0;
               end else begin
                  pos = 1;
                  while (pos < shadow_entries.size() && shadow_entries[pos].pri < ent.pri)
                     pos++;
               end
               shadow_entries.insert(pos, ent);
            end
         end
         MODE_DEQUEUE: begin
            if (shadow_entries.size() == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               ent = shadow_entries.pop_front();
               res.head_value = ent.value;
            end
         end
         default: ; // no-op code: nothing changes, status done
      endcase
      res.occupancy = OCC_W'(shadow_entries.size());
      return res;
   endfunction

   // Both channels are watched at the rising edge. The request side is handled
   // first, so even an answer in the same cycle as its request finds its expectation in place.
   always @(posedge clock) begin : scoreboard
      outcome_type want;
      if (reset) begin
         shadow_entries.delete();
         outcome_fifo.delete();
         shadow_cap = PRIO_CAP_RESET;
      end else begin
         if (csr_wr_en)
            shadow_cap = csr_wr_data;
         if (req_bus.valid && req_bus.ready)
            outcome_fifo.push_back(apply_queue_op(req_bus.mode, req_bus.item_value,
                                                  req_bus.item_priority));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (outcome_fifo.size() == 0) begin
               $error("response with nothing outstanding: head_value %0d status %0d occ %0d",
                      rsp_bus.head_value, rsp_bus.status, rsp_bus.occupancy);
               mismatch_count++;
            end else begin
               want = outcome_fifo.pop_front();
               if (rsp_bus.head_value !== want.head_value) begin
                  $error("head_value: expected %0d, got %0d", want.head_value,
                         rsp_bus.head_value);
                  mismatch_count++;
               end
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                  mismatch_count++;
               end
               if (rsp_bus.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", want.occupancy,
                         rsp_bus.occupancy);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Drives one request transaction and returns at the edge that takes it.
   // Valid stays high afterwards; the next call or wait_idle decides its level.
   task automatic send_op(input logic [1:0] op, input logic [VALUE_W-1:0] value,
                          input logic [PRIO_W-1:0] pri);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.mode          <= op;
      req_bus.item_value    <= value;
      req_bus.item_priority <= pri;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Stops sending and waits for every owed response; ends on a falling edge.
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (outcome_fifo.size() != 0)
         @(negedge clock);
   endtask

   // Cap register write; only between phases, with the queue logic quiet.
   task automatic write_cap(input logic [PRIO_W-1:0] cap);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random mix; enq_pct sets how strongly the mix fills the queue.
   // Priorities lean toward the current cap and to low numbers so that
   // equal priorities and clamping both show up often.
   task automatic run_random(input int count, input int enq_pct);
      int                r;
      logic [1:0]        op;
      logic [PRIO_W-1:0] pri;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 3)
            op = MODE_NOP;
         else if (r < enq_pct)
            op = ($urandom_range(0, 2) == 0) ? MODE_PLAIN : MODE_PRIO;
         else
            op = MODE_DEQUEUE;
         case ($urandom_range(0, 3))
            0: pri = PRIO_W'($urandom);
            1: pri = shadow_cap;
            2: pri = PRIO_W'($urandom_range(0, shadow_cap));
            default: pri = PRIO_W'($urandom_range(0, 3));
         endcase
         send_op(op, $urandom, pri);
      end
   endtask

   // Hand-picked sequence at the reset cap of 100: empty pop, no-op, extreme
   // values, clamping, front insert, ties with the head and with later entries.
   task automatic test_directed();
      send_op(MODE_DEQUEUE, 32'h1234_5678, 8'h00); // pop of empty queue
      send_op(MODE_NOP, 32'hFFFF_FFFF, 8'hFF);     // no-op on empty queue
      send_op(MODE_PLAIN, 32'h7FFF_FFFF, 8'h00);   // tail, priority = cap
      send_op(MODE_PRIO, 32'h8000_0000, 8'hFF);    // clamped to cap, ties head
      send_op(MODE_PRIO, 32'h0000_0000, 8'd100);   // ties head and later entry
      send_op(MODE_PRIO, 32'hFFFF_FFFF, 8'h00);    // strictly more urgent: front
      send_op(MODE_PRIO, 32'h0000_0001, 8'h00);    // ties new head, goes second
      send_op(MODE_PRIO, 32'h0000_0005, 8'd50);    // lands in the middle
      send_op(MODE_PLAIN, 32'h5555_5555, 8'hAA);   // priority field ignored
      send_op(MODE_NOP, 32'hAAAA_AAAA, 8'h55);     // no-op with entries held
      repeat (8)
         send_op(MODE_DEQUEUE, $urandom, PRIO_W'($urandom)); // last one hits empty
   endtask

   // Fill to the depth, push against the full queue in both modes, drain past empty.
   task automatic test_fill_and_drain();
      repeat (QUEUE_DEPTH)
         send_op(MODE_PRIO, $urandom, PRIO_W'($urandom));
      send_op(MODE_PLAIN, $urandom, PRIO_W'($urandom));
      send_op(MODE_PRIO, $urandom, 8'h00);
      repeat (QUEUE_DEPTH + 1)
         send_op(MODE_DEQUEUE, $urandom, PRIO_W'($urandom));
   endtask

   // Cap at both ends: 0 clamps everything to one priority, 255 clamps nothing.
   task automatic test_cap_extremes();
      write_cap(8'd0);
      run_random(60, 70);
      run_random(60, 30);
      write_cap(8'd255);
      run_random(80, 75);
      run_random(80, 25);
   endtask

   // No idling on either side: one transaction per cycle through the block.
   task automatic test_back_to_back();
      write_cap(8'd100);
      req_gap_pct = 0;
      rsp_gap_pct = 0;
      run_random(80, 65);
      run_random(70, 35);
      req_gap_pct = 24;
      rsp_gap_pct = 24;
   endtask

   // Tiny cap: nearly every priority enqueue ties with held entries.
   task automatic test_narrow_cap();
      write_cap(8'd3);
      run_random(60, 70);
      run_random(60, 30);
   endtask

   task automatic test_random_caps();
      repeat (4) begin
         write_cap(PRIO_W'($urandom));
         run_random(25, $urandom_range(30, 70));
      end
   endtask

   initial begin
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_bus.valid         = 1'b0;
      req_bus.mode          = MODE_PLAIN;
      req_bus.item_value    = '0;
      req_bus.item_priority = '0;
      rsp_bus.ready         = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_and_drain();
      test_cap_extremes();
      test_back_to_back();
      test_narrow_cap();
      test_random_caps();

      wait_idle();
      // keep running to catch any stray response
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog: many times the length of a slow correct run
   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
